[design/pngu_pkg.sv]
// Package: filter codes and the beat types shared by the scanline unfilter modules.
package pngu_pkg;

	typedef logic [2:0] filt_t;

	localparam filt_t FILT_NONE  = 3'd0;
	localparam filt_t FILT_SUB   = 3'd1;
	localparam filt_t FILT_UP    = 3'd2;
	localparam filt_t FILT_AVG   = 3'd3;
	localparam filt_t FILT_PAETH = 3'd4;
	localparam filt_t FILT_BAD   = 3'd5;

	localparam logic [7:0] FILT_MAX_CODE = 8'd4;

	typedef struct packed {
		filt_t      filt;
		logic [7:0] x;
		logic [7:0] a;
		logic [7:0] b;
		logic [7:0] c;
	} pred_in_t;

	typedef struct packed {
		logic [7:0] result;
		logic       bad;
	} pred_out_t;

endpackage

[design/pngu_row_mem.sv]
// Row-above store: one write port, one read port with registered read data.
module pngu_row_mem #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[design/pngu_predict.sv]
// Predictor: None, Sub, Up, Average and Paeth reconstruction of one byte.
module pngu_predict (
	input  pngu_pkg::pred_in_t  pin,
	output pngu_pkg::pred_out_t pout
);
	import pngu_pkg::*;

	logic [8:0] ab;
	logic [8:0] cc;
	logic [8:0] pa;
	logic [8:0] pb;
	logic [8:0] pc;
	logic [7:0] paeth;
	logic [7:0] pred;

	assign ab = {1'b0, pin.a} + {1'b0, pin.b};
	assign cc = {pin.c, 1'b0};
	assign pa = (pin.b > pin.c) ? {1'b0, pin.b - pin.c} : {1'b0, pin.c - pin.b};
	assign pb = (pin.a > pin.c) ? {1'b0, pin.a - pin.c} : {1'b0, pin.c - pin.a};
	assign pc = (ab > cc) ? (ab - cc) : (cc - ab);

	always_comb begin
		priority if (pa <= pb && pa <= pc) begin
			paeth = pin.a;
		end else if (pb <= pc) begin
			paeth = pin.b;
		end else begin
			paeth = pin.c;
		end
	end

	always_comb begin
		pout.bad = 1'b0;
		unique case (pin.filt)
			FILT_NONE:  pred = 8'd0;
			FILT_SUB:   pred = pin.a;
			FILT_UP:    pred = pin.b;
			FILT_AVG:   pred = ab[8:1];
			FILT_PAETH: pred = paeth;
			default: begin
				pred     = 8'd0;
				pout.bad = 1'b1;
			end
		endcase
		pout.result = pin.x + pred;
	end

endmodule

[design/png_scanline_unfilter_core.sv]
// Top level: PNG scanline unfilter, byte stream in, reconstructed byte stream out.
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tdata[7:0] data_byte, tuser image_start
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata[7:0] pixel_byte, tlast row_end,
//                                                tuser bad_filter
//  cfg       in   cfg_we                         cfg_wdata[10:0] row_pixels
//
//  One byte a cycle sustained while the output is not stalled; the row-memory read issues
//  on the accepting edge, the beat is reconstructed in the predict stage and then sits in the output register.
//  The rate is set by the single read and write port of the row memory.
//  Reset clears counters, row filter, neighbour bytes and valids; the row memory
//  is not cleared, and its read data is ignored on the first row of an image.
//  A stalled output holds the predict stage, which holds the input side.
module png_scanline_unfilter_core #(
	parameter int MAX_WIDTH       = 1024,
	parameter int BYTES_PER_PIXEL = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [10:0] cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tuser,   // [0] image_start
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [7:0] pixel_byte
	output logic        m_axis_tlast,
	output logic        m_axis_tuser    // [0] bad_filter
);
	import pngu_pkg::*;

	localparam int ROW_STORE = MAX_WIDTH * BYTES_PER_PIXEL;
	localparam int AW        = (ROW_STORE > 1) ? $clog2(ROW_STORE) : 1;
	localparam int PW        = $clog2(ROW_STORE + 1);
	localparam int KW        = (BYTES_PER_PIXEL > 1) ? $clog2(BYTES_PER_PIXEL) : 1;

	// configuration and row control
	logic [10:0]   row_pixels_q;
	logic [PW-1:0] pos_q;
	logic [KW-1:0] k_q;
	logic          first_q;
	filt_t         row_filter_q;

	logic [10:0]   wclamp;
	logic [PW-1:0] row_len;
	logic [PW-1:0] pos_eff;
	logic          first_eff;
	logic          in_go;
	logic          is_data;
	logic          is_last;
	logic [AW-1:0] rd_addr;

	// predict stage
	logic          valid_s1;
	logic          res_s1;
	logic [7:0]    x_s1;
	logic [AW-1:0] i_s1;
	logic [KW-1:0] k_s1;
	filt_t         filt_s1;
	logic          first_s1;
	logic          last_s1;
	logic          s1_go;

	logic [7:0]    left_q [BYTES_PER_PIXEL];
	logic [7:0]    ul_q   [BYTES_PER_PIXEL];
	logic [7:0]    mem_rdata;
	logic [7:0]    b_s1;
	pred_in_t      pin;
	pred_out_t     pout;
	logic          mem_we;

	// output register
	logic          out_valid_q;
	logic [7:0]    out_data_q;
	logic          out_last_q;
	logic          out_bad_q;

	always_comb begin
		if (row_pixels_q == 11'd0) begin
			wclamp = 11'd1;
		end else if (int'(row_pixels_q) > MAX_WIDTH) begin
			wclamp = 11'(MAX_WIDTH);
		end else begin
			wclamp = row_pixels_q;
		end
	end

	assign row_len   = PW'(wclamp) * PW'(BYTES_PER_PIXEL);
	assign pos_eff   = s_axis_tuser ? '0 : pos_q;
	assign first_eff = s_axis_tuser ? 1'b1 : first_q;
	assign is_data   = (pos_eff != '0);
	assign is_last   = (pos_eff >= row_len);
	assign rd_addr   = AW'(pos_eff - PW'(1));

	assign s1_go         = valid_s1 & (~res_s1 | ~out_valid_q | m_axis_tready);
	assign s_axis_tready = ~valid_s1 | s1_go;
	assign in_go         = s_axis_tvalid & s_axis_tready;
	assign mem_we        = s1_go & res_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_pixels_q <= 11'd1;
		end else if (cfg_we) begin
			row_pixels_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			k_q          <= '0;
			first_q      <= 1'b1;
			row_filter_q <= FILT_NONE;
		end else if (in_go) begin
			if (!is_data) begin
				row_filter_q <= (s_axis_tdata > FILT_MAX_CODE) ? FILT_BAD : s_axis_tdata[2:0];
				pos_q        <= PW'(1);
				k_q          <= '0;
				first_q      <= first_eff;
			end else if (is_last) begin
				pos_q   <= '0;
				first_q <= 1'b0;
			end else begin
				pos_q <= pos_q + PW'(1);
				k_q   <= (k_q == KW'(BYTES_PER_PIXEL - 1)) ? '0 : k_q + KW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_go) begin
			res_s1   <= is_data;
			x_s1     <= s_axis_tdata;
			i_s1     <= rd_addr;
			k_s1     <= k_q;
			filt_s1  <= row_filter_q;
			first_s1 <= first_eff;
			last_s1  <= is_last;
		end
	end

	pngu_row_mem #(
		.DEPTH (ROW_STORE),
		.AW    (AW)
	) u_row_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (i_s1),
		.wdata (pout.result),
		.re    (in_go & is_data),
		.raddr (rd_addr),
		.rdata (mem_rdata)
	);

	assign b_s1     = first_s1 ? 8'd0 : mem_rdata;
	assign pin.filt = filt_s1;
	assign pin.x    = x_s1;
	assign pin.a    = left_q[k_s1];
	assign pin.b    = b_s1;
	assign pin.c    = ul_q[k_s1];

	pngu_predict u_predict (
		.pin  (pin),
		.pout (pout)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int n = 0; n < BYTES_PER_PIXEL; n++) begin
				left_q[n] <= 8'd0;
				ul_q[n]   <= 8'd0;
			end
		end else if (s1_go) begin
			if (res_s1) begin
				left_q[k_s1] <= pout.result;
				ul_q[k_s1]   <= b_s1;
			end else begin
				for (int n = 0; n < BYTES_PER_PIXEL; n++) begin
					left_q[n] <= 8'd0;
					ul_q[n]   <= 8'd0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (mem_we) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			out_data_q <= pout.result;
			out_last_q <= last_s1;
			out_bad_q  <= pout.bad;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = out_bad_q;

	property p_no_same_addr;
		@(posedge clk) disable iff (!arst_n)
		(mem_we && in_go && is_data) |-> (i_s1 != rd_addr);
	endproperty
	a_no_same_addr: assert property (p_no_same_addr)
		else $error("row memory read and write hit one entry in one cycle");

	property p_stall_holds_input;
		@(posedge clk) disable iff (!arst_n)
		(valid_s1 && res_s1 && out_valid_q && !m_axis_tready) |-> !s_axis_tready;
	endproperty
	a_stall_holds_input: assert property (p_stall_holds_input)
		else $error("input taken while predict stage is blocked");

	property p_pos_bound;
		@(posedge clk) disable iff (!arst_n)
		1'b1 |-> (int'(pos_q) <= ROW_STORE);
	endproperty
	a_pos_bound: assert property (p_pos_bound)
		else $error("byte position beyond row store");

endmodule
